### rtl/core/cad_pkg.sv
// shared types, constants and register codes of the cartridge address decoder
`timescale 1ns / 1ps

package cad_pkg;

   // bus address and result widths
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned LOCAL_W = 23;
   localparam int unsigned REGION_W = 3;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned SRAM_MASK_W = 19;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_LAYOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_SIZE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRAM_MASK  = 2'd2;

   // rom size is kept in 4 KiB pages
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned ROM_PAGES_W = CSR_DATA_W - PAGE_SHIFT;
   // page number of a rom offset (offsets stay below 4 MiB)
   localparam int unsigned PAGE_W = 10;

   localparam logic [ROM_PAGES_W-1:0] ROM_PAGES_RESET = 12'h100;   // 1 MiB
   localparam logic [ROM_PAGES_W-1:0] ROM_PAGES_2MIB  = 12'h200;
   localparam logic [SRAM_MASK_W-1:0] SRAM_MASK_RESET = 19'h01FFF;

   // bank and offset landmarks
   localparam logic [7:0]  BANK_WRAM_LO = 8'h7E;
   localparam logic [7:0]  BANK_WRAM_HI = 8'h7F;
   localparam logic [7:0]  BANK_SRAM_LO = 8'h70;
   localparam logic [7:0]  BANK_SRAM_LO_END = 8'h7D;
   localparam logic [7:0]  BANK_SRAM_HI = 8'hF0;
   localparam logic [15:0] OFF_PPU_BASE = 16'h2000;
   localparam logic [15:0] OFF_CPU_BASE = 16'h4000;
   localparam logic [15:0] OFF_SYS_END  = 16'h6000;

   // quotient bits (restoring steps) per divider stage
   localparam int unsigned DIV_BITS_PER_STAGE = 2;

   typedef enum logic [REGION_W-1:0] {
      REGION_OPEN = 3'd0,
      REGION_WRAM = 3'd1,
      REGION_ROM  = 3'd2,
      REGION_SRAM = 3'd3,
      REGION_PPU  = 3'd4,
      REGION_CPU  = 3'd5
   } region_type;

   // one transaction in flight
   typedef struct packed {
      region_type              region;
      logic [LOCAL_W-1:0]      local_addr;   // final address for non-rom regions
      logic [PAGE_W-1:0]       page;         // rom offset, page part
      logic [PAGE_SHIFT-1:0]   low;          // rom offset, byte within page
      logic [ROM_PAGES_W-1:0]  rem;          // partial remainder of page mod size
   } pipe_type;

endpackage

### rtl/core/cad_div_stage.sv
// one pipeline stage of the rom page modulo: BITS_PER_STAGE restoring remainder steps
`timescale 1ns / 1ps

module cad_div_stage #(
   parameter int unsigned BITS_PER_STAGE = cad_pkg::DIV_BITS_PER_STAGE,
   parameter int unsigned STAGE_INDEX    = 0,
   parameter int unsigned PAD_BITS       = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cad_pkg::ROM_PAGES_W-1:0]     rom_pages,
   input  logic                                up_valid,
   input  cad_pkg::pipe_type                   up_data,
   input  logic                                down_ready,
   output logic                                ready,
   output logic                                valid_ff,
   output cad_pkg::pipe_type                   data_ff
);
   import cad_pkg::*;

   logic [ROM_PAGES_W-1:0] rem_v;
   logic [ROM_PAGES_W:0]   trial;
   pipe_type               data_in;
   logic                   valid_in;

   assign ready = !valid_ff || down_ready;

   // leading pad steps see zero bits and leave the remainder alone, so skip them
   always_comb begin
      int unsigned step;
      int unsigned bit_pos;
      rem_v = up_data.rem;
      trial = '0;
      for (int unsigned k = 0; k < BITS_PER_STAGE; k++) begin
         step = STAGE_INDEX * BITS_PER_STAGE + k;
         if (step >= PAD_BITS) begin
            bit_pos = PAGE_W - 1 - (step - PAD_BITS);
            trial = {rem_v, up_data.page[bit_pos[$clog2(PAGE_W)-1:0]]};
            if (trial >= {1'b0, rom_pages}) begin
               rem_v = ROM_PAGES_W'(trial - {1'b0, rom_pages});
            end else begin
               rem_v = trial[ROM_PAGES_W-1:0];
            end
         end
      end
      data_in = up_data;
      data_in.rem = rem_v;
      valid_in = up_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/cartridge_address_decoder.sv
// top level of the cartridge address decoder: decode, rom modulo pipeline, output register
`timescale 1ns / 1ps

// Decodes one 24-bit bus address a cycle while req_stall is low into a region
// code and a byte address in that region, after the LoROM or HiROM map chosen
// by csr register 0. One transaction enters per clock unless req_stall is high;
// on its way to rsp_valid it passes the decode register, the restoring divider
// stages that reduce the rom page number modulo the rom size in 4 KiB pages,
// and the output register. Each stage has its own valid bit and advances when
// the stage after it is empty or moving, so bubbles close up under rsp_stall
// and new transactions are still taken while a result waits. Configuration
// writes take effect at once and must only be issued while nothing is in
// flight; the block itself does not enforce this. Rom sizes are used rounded
// down to 4 KiB; a size below 4 KiB gives rom accesses a local address of zero.
module cartridge_address_decoder #(
   parameter int unsigned BITS_PER_STAGE = cad_pkg::DIV_BITS_PER_STAGE
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cad_pkg::ADDR_W-1:0]         req_cpu_address,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cad_pkg::REGION_W-1:0]       rsp_region,
   output logic [cad_pkg::LOCAL_W-1:0]        rsp_local_address,
   // configuration write port
   input  logic                               csr_write_enable,
   input  logic [cad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cad_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import cad_pkg::*;

   localparam int unsigned STAGES   = (PAGE_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int unsigned PAD_BITS = STAGES * BITS_PER_STAGE - PAGE_W;

   // configuration registers
   logic                   layout_ff;
   logic [ROM_PAGES_W-1:0] rom_pages_ff;
   logic [SRAM_MASK_W-1:0] save_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff    <= 1'b0;
         rom_pages_ff <= ROM_PAGES_RESET;
         save_mask_ff <= SRAM_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROM_LAYOUT: layout_ff    <= csr_write_data[0];
            CSR_ROM_SIZE:   rom_pages_ff <= csr_write_data[CSR_DATA_W-1:PAGE_SHIFT];
            CSR_SRAM_MASK:  save_mask_ff <= csr_write_data[SRAM_MASK_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // pipeline: stage 0 is the decode register, 1..STAGES are divider stages
   logic              stage_valid [0:STAGES];
   pipe_type          stage_data  [0:STAGES];
   logic              stage_ready [0:STAGES];
   logic              out_ready;

   // response register
   logic                rsp_valid_ff;
   logic [REGION_W-1:0] rsp_region_ff;
   logic [LOCAL_W-1:0]  rsp_local_ff;
   logic [LOCAL_W-1:0]  rsp_local_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------------
   // address decode
   // ---------------------------------------------------------------------------
   logic [7:0]  bank;
   logic [15:0] off;
   logic        sysbank;
   logic        big_rom;
   pipe_type    dec_in;

   assign bank    = req_cpu_address[23:16];
   assign off     = req_cpu_address[15:0];
   assign sysbank = !bank[6];
   // lorom mirrors past 2 MiB only in the upper bank half
   assign big_rom = rom_pages_ff > ROM_PAGES_2MIB;

   always_comb begin
      dec_in            = '0;
      dec_in.region     = REGION_OPEN;
      if (bank == BANK_WRAM_LO || bank == BANK_WRAM_HI) begin
         // full 128 KiB work ram
         dec_in.region     = REGION_WRAM;
         dec_in.local_addr = LOCAL_W'(req_cpu_address[16:0]);
      end else if (sysbank && off < OFF_SYS_END) begin
         // low pages of the system banks, same in both maps
         if (off < OFF_PPU_BASE) begin
            dec_in.region = REGION_WRAM;
         end else if (off < OFF_CPU_BASE) begin
            dec_in.region = REGION_PPU;
         end else begin
            dec_in.region = REGION_CPU;
         end
         dec_in.local_addr = LOCAL_W'(off);
      end else if (!layout_ff) begin
         // lorom: 32 KiB of rom in the upper half of each bank
         if (off[15]) begin
            dec_in.region = REGION_ROM;
            dec_in.page   = big_rom ? {bank[6:0], off[14:12]}
                                    : {1'b0, bank[5:0], off[14:12]};
            dec_in.low    = off[11:0];
         end else if ((bank >= BANK_SRAM_LO && bank <= BANK_SRAM_LO_END)
                      || bank >= BANK_SRAM_HI) begin
            dec_in.region     = REGION_SRAM;
            dec_in.local_addr = LOCAL_W'({bank[3:0], off[14:0]} & save_mask_ff);
         end
      end else begin
         // hirom: full 64 KiB banks, upper half only in the system banks
         if (off[15] || !sysbank) begin
            dec_in.region = REGION_ROM;
            dec_in.page   = {bank[5:0], off[15:12]};
            dec_in.low    = off[11:0];
         end else if (bank[5]) begin
            // save ram at 0x6000-0x7fff, 8 KiB per bank
            dec_in.region     = REGION_SRAM;
            dec_in.local_addr = LOCAL_W'(SRAM_MASK_W'({bank[4:0], off[12:0]})
                                         & save_mask_ff);
         end
      end
   end

   // decode register
   assign stage_ready[0] = !stage_valid[0] || stage_ready[(STAGES > 0) ? 1 : 0];
   assign req_stall      = !stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid[0] <= 1'b0;
      end else if (stage_ready[0]) begin
         stage_valid[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0] && req_valid) begin
         stage_data[0] <= dec_in;
      end
   end

   // ---------------------------------------------------------------------------
   // rom page modulo, BITS_PER_STAGE quotient bits per stage
   // ---------------------------------------------------------------------------
   for (genvar i = 1; i <= STAGES; i++) begin : g_div
      logic down_ready;
      if (i == STAGES) begin : g_last
         assign down_ready = out_ready;
      end else begin : g_mid
         assign down_ready = stage_ready[(i < STAGES) ? i + 1 : i];
      end

      cad_div_stage #(
         .BITS_PER_STAGE (BITS_PER_STAGE),
         .STAGE_INDEX    (i - 1),
         .PAD_BITS       (PAD_BITS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .rom_pages  (rom_pages_ff),
         .up_valid   (stage_valid[i-1]),
         .up_data    (stage_data[i-1]),
         .down_ready (down_ready),
         .ready      (stage_ready[i]),
         .valid_ff   (stage_valid[i]),
         .data_ff    (stage_data[i])
      );
   end

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_local_in = stage_data[STAGES].local_addr;
      if (stage_data[STAGES].region == REGION_ROM) begin
         // zero-size rom reads as offset zero
         if (rom_pages_ff == '0) begin
            rsp_local_in = '0;
         end else begin
            rsp_local_in = LOCAL_W'({stage_data[STAGES].rem, stage_data[STAGES].low});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stage_valid[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stage_valid[STAGES]) begin
         rsp_region_ff <= stage_data[STAGES].region;
         rsp_local_ff  <= rsp_local_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_region        = rsp_region_ff;
   assign rsp_local_address = rsp_local_ff;

endmodule

### rtl/core/cad_checker.sv
// port-level checks of the cartridge address decoder and their binding
`timescale 1ns / 1ps

module cad_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [cad_pkg::REGION_W-1:0]       rsp_region,
   input logic [cad_pkg::LOCAL_W-1:0]        rsp_local_address
);
   import cad_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_region)
                                && $stable(rsp_local_address))
      else $error("stalled response changed");

   // open bus always reads as address zero
   a_open_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == REGION_OPEN |-> rsp_local_address == '0)
      else $error("open bus with nonzero address");

   // work ram is 128 KiB
   a_wram_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == REGION_WRAM |-> rsp_local_address[22:17] == '0)
      else $error("work ram address out of range");

   // register regions carry only the 16-bit offset
   a_reg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_region == REGION_PPU || rsp_region == REGION_CPU)
      |-> rsp_local_address[22:16] == '0)
      else $error("register address out of range");

   // rom offsets stay below 4 MiB after the modulo
   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == REGION_ROM |-> rsp_local_address[22] == 1'b0)
      else $error("rom address out of range");

endmodule

bind cartridge_address_decoder cad_checker u_cad_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_region        (rsp_region),
   .rsp_local_address (rsp_local_address)
);
